/* rtl/srt_scheduler_with_aging_unit_assert.svh */
// Assertion macros shared by the scheduler's checker.
`ifndef SRT_SCHEDULER_WITH_AGING_UNIT_ASSERT_SVH
`define SRT_SCHEDULER_WITH_AGING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRTSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// Next-cycle implication, disabled during reset.
`define SRTSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

/* rtl/srtsa_pkg.sv */
// Types and constants shared by the scheduler table and its cells.
package srtsa_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] time_left;
      logic [31:0] last_run;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      idx_type     pos;
   } cell_ctrl_type;

   // Token that walks the chain during a select, carrying the best candidates so far.
   typedef struct packed {
      logic      active;
      entry_type min_ent;
      idx_type   min_idx;
      logic      stv;
      entry_type stv_ent;
      idx_type   stv_idx;
   } scan_type;

endpackage

/* rtl/srtsa_cell.sv */
// One table slot: holds an entry, shifts on insert and remove, and runs one scan step.
module srtsa_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  srtsa_pkg::idx_type      cell_idx,
   input  srtsa_pkg::cell_ctrl_type ctrl,
   input  srtsa_pkg::entry_type    new_ent,
   input  logic                    left_vld,
   input  srtsa_pkg::entry_type    left_ent,
   input  logic                    right_vld,
   input  srtsa_pkg::entry_type    right_ent,
   input  logic [31:0]             now_time,
   input  logic [31:0]             limit,
   input  srtsa_pkg::scan_type     scan_in,
   output logic                    vld,
   output srtsa_pkg::entry_type    ent,
   output srtsa_pkg::scan_type     scan_out
);
   import srtsa_pkg::*;

   logic      vld_ff, vld_in;
   entry_type ent_ff, ent_in;
   scan_type  scan_ff, scan_in_nxt;
   logic      first_cell, self_le, left_le, left_vld_eff;
   logic [31:0] age;
   logic      starving;

   assign first_cell   = (cell_idx == '0);
   assign left_vld_eff = first_cell | left_vld;
   assign self_le      = vld_ff && (ent_ff.id <= new_ent.id);
   assign left_le      = first_cell || (left_vld && (left_ent.id <= new_ent.id));
   assign age          = now_time - ent_ff.last_run;
   assign starving     = vld_ff && (age >= limit);

   always_comb begin
      vld_in = vld_ff;
      ent_in = ent_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            vld_in = vld_ff | left_vld_eff;
            if (!self_le) begin
               ent_in = left_le ? new_ent : left_ent;
            end
         end
         CELL_REMOVE: begin
            if (cell_idx >= ctrl.pos) begin
               vld_in = right_vld;
               ent_in = right_ent;
            end
         end
         default: begin
            vld_in = vld_ff;
            ent_in = ent_ff;
         end
      endcase
   end

   always_comb begin
      scan_in_nxt = scan_in;
      if (scan_in.active && vld_ff) begin
         if (first_cell || (ent_ff.time_left < scan_in.min_ent.time_left)) begin
            scan_in_nxt.min_ent = ent_ff;
            scan_in_nxt.min_idx = cell_idx;
         end
         if (!scan_in.stv && starving) begin
            scan_in_nxt.stv     = 1'b1;
            scan_in_nxt.stv_ent = ent_ff;
            scan_in_nxt.stv_idx = cell_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff         <= 1'b0;
         scan_ff.active <= 1'b0;
      end else begin
         vld_ff         <= vld_in;
         scan_ff.active <= scan_in_nxt.active;
      end
      ent_ff          <= ent_in;
      scan_ff.min_ent <= scan_in_nxt.min_ent;
      scan_ff.min_idx <= scan_in_nxt.min_idx;
      scan_ff.stv     <= scan_in_nxt.stv;
      scan_ff.stv_ent <= scan_in_nxt.stv_ent;
      scan_ff.stv_idx <= scan_in_nxt.stv_idx;
   end

   assign vld      = vld_ff;
   assign ent      = ent_ff;
   assign scan_out = scan_ff;

endmodule

/* rtl/srt_scheduler_with_aging_unit.sv */
// Top level of the shortest-remaining-time scheduler table with starvation aging.
// The table is a chain of DEPTH slot cells kept packed in ascending id order. An insert
// updates every cell at once at the accept edge and its result beat is offered in the
// next cycle. A select sends a token down the chain, one cell per cycle, that tracks the
// least remaining time and the first starving entry; its result beat is registered as the
// token leaves the last cell, and the chosen entry is removed at the same edge. A select on
// an empty table and an insert into a full table answer in the next cycle. One request is
// in flight at a time: the next is taken no earlier than the edge at which the previous
// result beat is taken.
module srt_scheduler_with_aging_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_proc_id,
   input  logic [31:0] req_run_time_left,
   input  logic [31:0] req_last_run_time,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic        rsp_table_full,
   output logic [15:0] rsp_chosen_id,
   output logic [31:0] rsp_chosen_time_left,
   output logic [31:0] rsp_chosen_last_run,
   output logic        rsp_was_starving,
   output logic [4:0]  rsp_entry_count,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import srtsa_pkg::*;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SELECT = 1'b1;

   state_type     state_ff, state_in;
   cnt_type       count_ff, count_in;
   logic [31:0]   limit_ff;
   logic [31:0]   now_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff, found_in;
   logic          full_ff, full_in;
   entry_type     chosen_ff, chosen_in;
   logic          starv_ff, starv_in;

   logic          can_take, accept;
   cell_ctrl_type ctrl;
   entry_type     new_ent;
   scan_type      scan_head;
   scan_type      scan_bus [DEPTH+1];
   logic          cell_vld [DEPTH];
   entry_type     cell_ent [DEPTH];
   scan_type      scan_end;
   logic [31:0]   scan_now;

   assign can_take  = (state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;
   assign scan_end  = scan_bus[DEPTH];

   // The first cell scans in the accept cycle, before the request time is registered.
   assign scan_now  = accept ? req_now_time : now_ff;

   assign new_ent.id        = req_proc_id;
   assign new_ent.time_left = req_run_time_left;
   assign new_ent.last_run  = req_last_run_time;

   always_comb begin
      scan_head        = '0;
      scan_head.active = accept && (req_type == REQ_SELECT) && (count_ff != '0);
   end
   assign scan_bus[0] = scan_head;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      full_in      = full_ff;
      chosen_in    = chosen_ff;
      starv_in     = starv_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.pos     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chosen_in = '0;
               starv_in  = 1'b0;
               full_in   = 1'b0;
               found_in  = 1'b0;
               if (req_type == REQ_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CNT_W'(DEPTH)) begin
                     full_in = 1'b1;
                  end else begin
                     found_in = 1'b1;
                     count_in = count_ff + 1'b1;
                     ctrl.op  = CELL_INSERT;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end.active) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               found_in     = 1'b1;
               starv_in     = scan_end.stv;
               chosen_in    = scan_end.stv ? scan_end.stv_ent : scan_end.min_ent;
               ctrl.op      = CELL_REMOVE;
               ctrl.pos     = scan_end.stv ? scan_end.stv_idx : scan_end.min_idx;
               count_in     = count_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= 32'd100;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
      found_ff  <= found_in;
      full_ff   <= full_in;
      chosen_ff <= chosen_in;
      starv_ff  <= starv_in;
      if (accept) begin
         now_ff <= req_now_time;
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic      left_vld_w, right_vld_w;
      entry_type left_ent_w, right_ent_w;

      if (k == 0) begin : g_first
         assign left_vld_w = 1'b0;
         assign left_ent_w = '0;
      end else begin : g_mid_l
         assign left_vld_w = cell_vld[k-1];
         assign left_ent_w = cell_ent[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign right_vld_w = 1'b0;
         assign right_ent_w = '0;
      end else begin : g_mid_r
         assign right_vld_w = cell_vld[k+1];
         assign right_ent_w = cell_ent[k+1];
      end

      srtsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(k)),
         .ctrl      (ctrl),
         .new_ent   (new_ent),
         .left_vld  (left_vld_w),
         .left_ent  (left_ent_w),
         .right_vld (right_vld_w),
         .right_ent (right_ent_w),
         .now_time  (scan_now),
         .limit     (limit_ff),
         .scan_in   (scan_bus[k]),
         .vld       (cell_vld[k]),
         .ent       (cell_ent[k]),
         .scan_out  (scan_bus[k+1])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = found_ff;
   assign rsp_table_full       = full_ff;
   assign rsp_chosen_id        = chosen_ff.id;
   assign rsp_chosen_time_left = chosen_ff.time_left;
   assign rsp_chosen_last_run  = chosen_ff.last_run;
   assign rsp_was_starving     = starv_ff;
   assign rsp_entry_count      = 5'(count_ff);

endmodule

/* rtl/srtsa_checker.sv */
// Port-level checker for the scheduler table, bound to the top level.
`include "srt_scheduler_with_aging_unit_assert.svh"

module srtsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic        rsp_table_full,
   input logic        rsp_was_starving,
   input logic [4:0]  rsp_entry_count,
   input logic [15:0] rsp_chosen_id
);
   import srtsa_pkg::*;

   // A stalled result beat stays offered.
   `SRTSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A dropped insert never reports success.
   `SRTSA_ASSERT_IMPL(a_full_not_found, clock, reset, rsp_valid && rsp_table_full, !rsp_found)

   // A dropped insert leaves the table at capacity.
   `SRTSA_ASSERT_IMPL(a_full_count, clock, reset, rsp_valid && rsp_table_full, rsp_entry_count == 5'(DEPTH))

   // The starvation rule only fires when an entry was returned.
   `SRTSA_ASSERT_IMPL(a_starv_found, clock, reset, rsp_valid && rsp_was_starving, rsp_found && !rsp_table_full)

   // A result that found nothing carries no id.
   `SRTSA_ASSERT_IMPL(a_none_zero_id, clock, reset, rsp_valid && !rsp_found, rsp_chosen_id == 16'd0)

endmodule

bind srt_scheduler_with_aging_unit srtsa_checker u_srtsa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_table_full   (rsp_table_full),
   .rsp_was_starving (rsp_was_starving),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_chosen_id    (rsp_chosen_id)
);

/* sim/srt_sched_tb_pkg.sv */
// Request kinds shared by the scheduler testbench top and its checker.
`timescale 1ns / 100ps
package srt_sched_tb_pkg;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_SELECT = 1'b1
   } req_kind_type;

endpackage

/* sim/srt_scheduler_checker.sv */
// Checker that mirrors the scheduler table and compares every result beat with its prediction.
`timescale 1ns / 100ps
module srt_scheduler_checker
   import srtsa_pkg::*;
   import srt_sched_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_proc_id,
   input  logic [31:0] req_run_time_left,
   input  logic [31:0] req_last_run_time,
   input  logic [31:0] req_now_time,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_found,
   input  logic        rsp_table_full,
   input  logic [15:0] rsp_chosen_id,
   input  logic [31:0] rsp_chosen_time_left,
   input  logic [31:0] rsp_chosen_last_run,
   input  logic        rsp_was_starving,
   input  logic [4:0]  rsp_entry_count,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int unsigned mismatch_count,
   output int unsigned backlog,
   output int unsigned accepted,
   output int unsigned aged_picks,
   output int unsigned full_drops,
   output int unsigned empty_selects
);

   typedef struct packed {
      logic        found;
      logic        table_full;
      logic [15:0] chosen_id;
      logic [31:0] chosen_time_left;
      logic [31:0] chosen_last_run;
      logic        was_starving;
      logic [4:0]  entry_count;
   } reply_type;

   entry_type   slots[DEPTH];
   int unsigned held;
   logic [31:0] aging_limit;
   reply_type   owed_replies[$];
   reply_type   predicted;
   reply_type   observed;
   int unsigned beat_index;

   initial begin
      mismatch_count = 0;
      backlog        = 0;
      accepted       = 0;
      aged_picks     = 0;
      full_drops     = 0;
      empty_selects  = 0;
      beat_index     = 0;
      held           = 0;
      aging_limit    = 32'd100;
   end

   // Applies one request to the mirrored table and returns the result it must produce.
   function automatic reply_type schedule_request(input req_kind_type kind,
                                                  input entry_type ent,
                                                  input logic [31:0] now);
      reply_type   r;
      int unsigned pos;
      int unsigned pick;
      int unsigned k;
      logic        aged;
      logic [31:0] age;
      r = '0;
      if (kind == REQ_INSERT) begin
         if (held >= DEPTH) begin
            r.table_full = 1'b1;
            full_drops++;
         end else begin
            // An equal id goes after its equal, so the scan stops at the first larger id.
            pos = 0;
            while (pos < held && slots[pos].id <= ent.id)
               pos++;
            for (k = held; k > pos; k--)
               slots[k] = slots[k - 1];
            slots[pos] = ent;
            held++;
            r.found = 1'b1;
         end
      end else if (held == 0) begin
         empty_selects++;
      end else begin
         pick = 0;
         aged = 1'b0;
         for (k = 1; k < held; k++)
            if (slots[k].time_left < slots[pick].time_left)
               pick = k;
         // The first starving entry in id order overrides the shortest remaining time.
         for (k = 0; k < held; k++) begin
            age = now - slots[k].last_run;
            if (!aged && age >= aging_limit) begin
               pick = k;
               aged = 1'b1;
            end
         end
         r.found            = 1'b1;
         r.was_starving     = aged;
         r.chosen_id        = slots[pick].id;
         r.chosen_time_left = slots[pick].time_left;
         r.chosen_last_run  = slots[pick].last_run;
         if (aged)
            aged_picks++;
         for (k = pick; k + 1 < held; k++)
            slots[k] = slots[k + 1];
         held--;
      end
      r.entry_count = held[4:0];
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("beat %0d: %s expected %0h, got %0h", beat_index, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_replies.delete();
         held        = 0;
         aging_limit = 32'd100;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_found, rsp_table_full, rsp_chosen_id, rsp_chosen_time_left,
                         rsp_chosen_last_run, rsp_was_starving, rsp_entry_count};
            if (owed_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat %0d: result arrived with no request outstanding", beat_index);
            end else begin
               predicted = owed_replies.pop_front();
               compare_field("found", 32'(observed.found), 32'(predicted.found));
               compare_field("table_full", 32'(observed.table_full),
                             32'(predicted.table_full));
               compare_field("chosen_id", 32'(observed.chosen_id), 32'(predicted.chosen_id));
               compare_field("chosen_time_left", observed.chosen_time_left,
                             predicted.chosen_time_left);
               compare_field("chosen_last_run", observed.chosen_last_run,
                             predicted.chosen_last_run);
               compare_field("was_starving", 32'(observed.was_starving),
                             32'(predicted.was_starving));
               compare_field("entry_count", 32'(observed.entry_count),
                             32'(predicted.entry_count));
            end
            beat_index++;
         end
         if (req_valid && !req_stall) begin
            owed_replies.push_back(schedule_request(req_kind_type'(req_type),
                                                    '{req_proc_id, req_run_time_left,
                                                      req_last_run_time},
                                                    req_now_time));
            accepted++;
         end
         if (csr_we)
            aging_limit = csr_wdata;
      end
      backlog = owed_replies.size();
   end

endmodule

/* sim/tb_srt_scheduler_with_aging_unit.sv */
// Testbench top for the scheduler table: request and stall stimulus, limit writes and verdict.
`timescale 1ns / 100ps
module tb_srt_scheduler_with_aging_unit;
   import srtsa_pkg::DEPTH;
   import srt_sched_tb_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 235;

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic        req_type          = 1'b0;
   logic [15:0] req_proc_id       = '0;
   logic [31:0] req_run_time_left = '0;
   logic [31:0] req_last_run_time = '0;
   logic [31:0] req_now_time      = '0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic        rsp_found;
   logic        rsp_table_full;
   logic [15:0] rsp_chosen_id;
   logic [31:0] rsp_chosen_time_left;
   logic [31:0] rsp_chosen_last_run;
   logic        rsp_was_starving;
   logic [4:0]  rsp_entry_count;
   logic        csr_we            = 1'b0;
   logic [31:0] csr_wdata         = '0;

   int unsigned mismatch_count;
   int unsigned backlog;
   int unsigned accepted;
   int unsigned aged_picks;
   int unsigned full_drops;
   int unsigned empty_selects;

   int unsigned stall_pct  = 25;
   int unsigned gap_pct    = 25;
   bit          long_hold  = 1'b0;
   logic [31:0] tick       = 32'd1000;
   logic [31:0] age_spread = 32'd200;

   srt_scheduler_with_aging_unit u_dut (.*);

   srt_scheduler_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("no progress within %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off when asked for.
   initial begin : result_side
      int unsigned burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            for (int c = 0; c < HOLD_CYCLES; c++)
               @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic offer(input req_kind_type kind, input logic [15:0] id,
                        input logic [31:0] left, input logic [31:0] last,
                        input logic [31:0] now);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_proc_id       <= id;
      req_run_time_left <= left;
      req_last_run_time <= last;
      req_now_time      <= now;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (backlog == 0);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value, input int unsigned idle_pct);
      req_valid <= 1'b0;
      wait (backlog == 0);
      @(posedge clock);
      stall_pct = idle_pct;
      gap_pct   = idle_pct;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_request(input bit filling);
      req_kind_type kind;
      logic [15:0]  id;
      logic [31:0]  left;
      logic [31:0]  last;
      logic [31:0]  now;
      kind = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? REQ_INSERT : REQ_SELECT;
      case ($urandom_range(0, 9))
         0:       id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1, 2, 3: id = 16'($urandom);
         default: id = 16'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
         0:          left = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         1, 2, 3, 4: left = $urandom;
         default:    left = $urandom_range(0, 20);
      endcase
      if ($urandom_range(0, 3) != 0)
         tick = tick + $urandom_range(0, 20);
      // A last run just past the current tick reads as the largest possible age.
      case ($urandom_range(0, 9))
         0:       last = $urandom;
         1:       last = tick + 32'd1;
         default: last = tick - $urandom_range(0, age_spread);
      endcase
      now = ($urandom_range(0, 9) == 0) ? $urandom : tick;
      offer(kind, id, left, last, now);
   endtask

   task automatic run_phase(input logic [31:0] limit, input int unsigned idle_pct,
                            input bit squeeze);
      write_limit(limit, idle_pct);
      age_spread = (limit < 8) ? 32'd8 : ((limit > 200) ? 32'd400 : 2 * limit);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (squeeze && i == 60) begin
            // The result side holds off while requests keep coming.
            req_valid <= 1'b0;
            @(posedge clock);
            long_hold = 1'b1;
            @(negedge clock);
         end
         if (squeeze && i == 150)
            drain();
         random_request(((i / 30) % 2) == 0);
      end
   endtask

   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      offer(REQ_SELECT, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
      offer(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      offer(REQ_INSERT, 16'h0000, 32'h0, 32'h0, 32'h0);
      offer(REQ_INSERT, 16'd5, 32'd10, 32'd50, 32'h0);
      offer(REQ_INSERT, 16'd5, 32'd10, 32'd60, 32'h0);
      offer(REQ_INSERT, 16'd5, 32'd3, 32'd20, 32'h0);
      for (int i = 0; i < 11; i++)
         offer(REQ_INSERT, 16'(100 + 7 * i), 32'(1000 + i), 32'd50, 32'h0);
      offer(REQ_INSERT, 16'd42, 32'd1, 32'd1, 32'h0);
      // Aged pick in id order, then shortest time, a tie, and a wrapped age.
      offer(REQ_SELECT, 16'h0, 32'h0, 32'h0, 32'd250);
      offer(REQ_SELECT, 16'h0, 32'h0, 32'h0, 32'd60);
      offer(REQ_SELECT, 16'h0, 32'h0, 32'h0, 32'd60);
      offer(REQ_SELECT, 16'h0, 32'h0, 32'h0, 32'd0);

      run_phase(32'h0, 25, 1'b0);
      run_phase(32'hFFFF_FFFF, 0, 1'b0);
      run_phase(32'd1, 25, 1'b1);
      run_phase(32'd37, 40, 1'b0);
      run_phase(32'd100, 0, 1'b0);
      run_phase(32'd1000, 25, 1'b0);
      run_phase(32'h8000_0000, 25, 1'b0);
      run_phase($urandom_range(2, 300), 15, 1'b1);

      req_valid <= 1'b0;
      wait (backlog == 0);
      repeat (DEPTH + 8) @(posedge clock);
      $display("%0d requests under eight aging limits from zero to all ones", accepted);
      $display("%0d aged picks, %0d inserts dropped when full, %0d selects on an empty table",
               aged_picks, full_drops, empty_selects);
      if (mismatch_count == 0 && backlog == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
